// File: rtl/core/rmsm_pkg.sv
package rmsm_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int RMS_W    = 31;
    localparam int SCALE_W  = 16;
    localparam int SHIFT_W  = 5;
    localparam int COUNT_W  = 16;
    localparam int OFF_W    = 33;   // Q16.16 offset with sign
    localparam int FRAC_Q   = 16;   // fraction bits of the offset
    localparam int FILT_SHIFT = 8;  // filtered value is Q.8
    localparam int SQ_W     = 48;   // square of a Q.8 value below 2^24
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 2;
    localparam int PROD_W   = ROOT_W + SCALE_W;

    // Output rounding and saturation
    localparam int ROUND_SHIFT = 8;
    localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

    // Clamp limits of the shift registers
    localparam logic [SHIFT_W-1:0] WS_MIN = SHIFT_W'(1);
    localparam logic [SHIFT_W-1:0] WS_MAX = SHIFT_W'(16);
    localparam logic [SHIFT_W-1:0] OS_MIN = SHIFT_W'(4);
    localparam logic [SHIFT_W-1:0] OS_MAX = SHIFT_W'(16);

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(250);
    localparam logic [SHIFT_W-1:0] WS_RST    = SHIFT_W'(11);
    localparam logic [SHIFT_W-1:0] OS_RST    = SHIFT_W'(10);

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE        = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SHIFT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_SHIFT = REG_IDX_W'(2);

    localparam int QUEUE_DEPTH_DEF = 4;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [SHIFT_W-1:0] window_shift;
        logic [SHIFT_W-1:0] offset_shift;
    } cfg_t;

    // One closed window: the two sums of squares
    typedef struct packed {
        logic [SUM_W-1:0] sum_one;
        logic [SUM_W-1:0] sum_two;
    } window_t;

endpackage

// File: rtl/core/rmsm_in_if.sv
interface rmsm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmsm_pkg::SAMPLE_W-1:0] sample_ct1;
    logic signed [rmsm_pkg::SAMPLE_W-1:0] sample_ct2;

    modport source (output valid, output sample_ct1, output sample_ct2, input ready);
    modport sink   (input valid, input sample_ct1, input sample_ct2, output ready);
endinterface

// File: rtl/core/rmsm_out_if.sv
interface rmsm_out_if;
    logic                             valid;
    logic                             ready;
    logic [rmsm_pkg::RMS_W-1:0]       rms_ct1;
    logic [rmsm_pkg::RMS_W-1:0]       rms_ct2;

    modport source (output valid, output rms_ct1, output rms_ct2, input ready);
    modport sink   (input valid, input rms_ct1, input rms_ct2, output ready);
endinterface

// File: rtl/core/rmsm_regs.sv
module rmsm_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rmsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rmsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output rmsm_pkg::cfg_t                  cfg
);
    import rmsm_pkg::*;

    logic [SCALE_W-1:0]   scale_reg;
    logic [SHIFT_W-1:0]   ws_reg;
    logic [SHIFT_W-1:0]   os_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RST;
            ws_reg    <= WS_RST;
            os_reg    <= OS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SCALE:        scale_reg <= pwdata[SCALE_W-1:0];
                REG_WINDOW_SHIFT: ws_reg    <= pwdata[SHIFT_W-1:0];
                REG_OFFSET_SHIFT: os_reg    <= pwdata[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SCALE:        prdata = APB_DATA_W'(scale_reg);
            REG_WINDOW_SHIFT: prdata = APB_DATA_W'(ws_reg);
            REG_OFFSET_SHIFT: prdata = APB_DATA_W'(os_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp the shifts into their working ranges
    always_comb
    begin
        cfg.scale        = scale_reg;
        cfg.window_shift = (ws_reg < WS_MIN) ? WS_MIN : ((ws_reg > WS_MAX) ? WS_MAX : ws_reg);
        cfg.offset_shift = (os_reg < OS_MIN) ? OS_MIN : ((os_reg > OS_MAX) ? OS_MAX : os_reg);
    end

endmodule

// File: rtl/core/rmsm_front.sv
module rmsm_front #(
    parameter int QUEUE_DEPTH = rmsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rmsm_in_if.sink                              samples,
    input  rmsm_pkg::cfg_t                       cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_count,
    output logic                                 push,
    output rmsm_pkg::window_t                    push_data
);
    import rmsm_pkg::*;

    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int XW  = OFF_W + 1;
    localparam int FW  = XW - FILT_SHIFT;
    localparam int SXW = XW - SAMPLE_W - FRAC_Q;

    logic                       accept;
    logic [CW:0]                committed;
    logic [COUNT_W:0]           taken;
    logic [COUNT_W:0]           limit;
    logic                       last_a;
    logic [COUNT_W-1:0]         count_reg;

    logic signed [SAMPLE_W-1:0] smp_a [2];
    logic signed [XW-1:0]       x_a [2];
    logic signed [XW-1:0]       off_ext [2];
    logic signed [XW-1:0]       diff_a [2];
    logic signed [XW-1:0]       step_a [2];
    logic signed [XW-1:0]       sum_a [2];
    logic signed [OFF_W-1:0]    off_reg [2];

    // stage one: sample held for the filter output
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic signed [SAMPLE_W-1:0] s1_smp_reg [2];

    logic signed [XW-1:0]       x_b [2];
    logic signed [XW-1:0]       diff_b [2];
    logic signed [FW-1:0]       f_b [2];
    logic signed [2*FW-1:0]     sq_b [2];

    // stage two: squares
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic [SQ_W-1:0]            s2_sq_reg [2];

    logic [SUM_W-1:0]           sum_reg [2];
    logic [SUM_W-1:0]           sum_add [2];

    // Hold off while every queue slot is claimed by a stored or in-flight window
    assign committed = {1'b0, q_count}
                     + (CW+1)'(s1_valid_reg & s1_last_reg)
                     + (CW+1)'(s2_valid_reg & s2_last_reg);
    assign samples.ready = committed < (CW+1)'(QUEUE_DEPTH);
    assign accept = samples.valid && samples.ready;

    assign taken  = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign limit  = {{COUNT_W{1'b0}}, 1'b1} << cfg.window_shift;
    assign last_a = taken >= limit;

    assign smp_a[0] = samples.sample_ct1;
    assign smp_a[1] = samples.sample_ct2;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            x_a[c]     = {{SXW{smp_a[c][SAMPLE_W-1]}}, smp_a[c], {FRAC_Q{1'b0}}};
            off_ext[c] = {off_reg[c][OFF_W-1], off_reg[c]};
            diff_a[c]  = x_a[c] - off_ext[c];
            step_a[c]  = diff_a[c] >>> cfg.offset_shift;
            sum_a[c]   = off_ext[c] + step_a[c];

            // off_reg already carries this item's offset
            x_b[c]    = {{SXW{s1_smp_reg[c][SAMPLE_W-1]}}, s1_smp_reg[c], {FRAC_Q{1'b0}}};
            diff_b[c] = x_b[c] - off_ext[c];
            f_b[c]    = diff_b[c][XW-1:FILT_SHIFT];
            sq_b[c]   = f_b[c] * f_b[c];

            sum_add[c] = sum_reg[c] + SUM_W'(s2_sq_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                off_reg[c] <= '0;
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && last_a;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg && s1_last_reg;
            if (accept)
            begin
                count_reg <= last_a ? '0 : taken[COUNT_W-1:0];
                for (int c = 0; c < 2; c++)
                begin
                    off_reg[c] <= sum_a[c][OFF_W-1:0];
                end
            end
            if (s2_valid_reg)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    sum_reg[c] <= s2_last_reg ? '0 : sum_add[c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int c = 0; c < 2; c++)
            begin
                s1_smp_reg[c] <= smp_a[c];
            end
        end
        if (s1_valid_reg)
        begin
            for (int c = 0; c < 2; c++)
            begin
                s2_sq_reg[c] <= sq_b[c][SQ_W-1:0];
            end
        end
    end

    assign push              = s2_valid_reg && s2_last_reg;
    assign push_data.sum_one = sum_add[0];
    assign push_data.sum_two = sum_add[1];

endmodule

// File: rtl/core/rmsm_queue.sv
module rmsm_queue #(
    parameter int QUEUE_DEPTH = rmsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  rmsm_pkg::window_t                push_data,
    input  logic                             pop,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    output rmsm_pkg::window_t                rd_data
);
    import rmsm_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    window_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// File: rtl/core/rmsm_back.sv
module rmsm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rmsm_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  rmsm_pkg::window_t q_data,
    output logic              pop,
    rmsm_out_if.source        results
);
    import rmsm_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int CAND_W = REM_W + 2;
    localparam int RND_W  = PROD_W + 1;
    localparam int SHR_W  = RND_W - ROUND_SHIFT;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_ROOT = 4'b0010,
        B_MUL  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t             state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    v_reg [2];
    logic [REM_W-1:0]    rem_reg [2];
    logic [ROOT_W-1:0]   root_reg [2];
    logic [PROD_W-1:0]   prod_reg [2];
    logic                out_valid_reg;
    logic [RMS_W-1:0]    rms_reg [2];

    logic [CAND_W-1:0]   cand [2];
    logic [CAND_W-1:0]   trial [2];
    logic                ge [2];
    logic [CAND_W-1:0]   rem_next [2];
    logic [RND_W-1:0]    rnd [2];
    logic [SHR_W-1:0]    shr [2];
    logic [RMS_W-1:0]    rms_next [2];
    logic                out_free;

    assign pop      = (state_reg == B_IDLE) && q_valid;
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            // one root digit per cycle
            cand[c]     = {rem_reg[c], v_reg[c][SUM_W-1:SUM_W-2]};
            trial[c]    = {2'b00, root_reg[c], 2'b01};
            ge[c]       = cand[c] >= trial[c];
            rem_next[c] = ge[c] ? cand[c] - trial[c] : cand[c];

            // round half up to units/256, then saturate
            rnd[c] = {1'b0, prod_reg[c]} + RND_W'(1 << (ROUND_SHIFT - 1));
            shr[c] = rnd[c][RND_W-1:ROUND_SHIFT];
            rms_next[c] = (|shr[c][SHR_W-1:RMS_W]) ? RMS_MAX : shr[c][RMS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == B_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= B_ROOT;
                    end
                end
                B_ROOT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(ROOT_W - 1))
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (pop)
            begin
                v_reg[c]    <= (c == 0) ? q_data.sum_one >> cfg.window_shift
                                        : q_data.sum_two >> cfg.window_shift;
                rem_reg[c]  <= '0;
                root_reg[c] <= '0;
            end
            else if (state_reg == B_ROOT)
            begin
                v_reg[c]    <= {v_reg[c][SUM_W-3:0], 2'b00};
                rem_reg[c]  <= rem_next[c][REM_W-1:0];
                root_reg[c] <= {root_reg[c][ROOT_W-2:0], ge[c]};
            end
            if (state_reg == B_MUL)
            begin
                prod_reg[c] <= root_reg[c] * cfg.scale;
            end
            if ((state_reg == B_OUT) && out_free)
            begin
                rms_reg[c] <= rms_next[c];
            end
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.rms_ct1 = rms_reg[0];
    assign results.rms_ct2 = rms_reg[1];

endmodule

// File: rtl/core/dual_channel_rms_meter.sv
// Path: a window result reaches the output register after the transfer of its last
//   sample through the front stages, queue, 32 root steps, multiply and rounding.
// Throughput: one sample pair per cycle while the window queue has room; the back end
//   takes each window through its root steps, multiply and output, so short windows
//   throttle the input once the window queue fills, as does a stalled result.
// rst_n is asynchronous, active low: offsets, sums, count, queue and output clear;
//   registers return to scale 250, window shift 11, offset shift 10.
module dual_channel_rms_meter #(
    parameter int QUEUE_DEPTH = rmsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rmsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rmsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // sample pairs in, window results out
    rmsm_in_if.sink                         samples,
    rmsm_out_if.source                      results
);
    import rmsm_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cfg_t          cfg;
    logic          push;
    window_t       push_data;
    logic          pop;
    logic [CW-1:0] q_count;
    window_t       q_data;

    // Register file: scale, window shift and offset shift, with the shifts
    // clamped into range before they reach the datapath.
    rmsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: per-sample offset filter, square and sum, window count.
    // Take a sample only while a queue slot is free for every window that
    // could close in flight, so the pipeline never has to stall.
    rmsm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    // Queue of closed windows: decouple accumulation from root extraction.
    rmsm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .count     (q_count),
        .rd_data   (q_data)
    );

    // Back end: mean, bit-serial square root for both channels together,
    // scale, round and saturate into the output register. Hold a result
    // until its transfer completes; the front carries on meanwhile.
    rmsm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_count != '0),
        .q_data  (q_data),
        .pop     (pop),
        .results (results)
    );

endmodule

// File: rtl/core/rmsm_checker.sv
module rmsm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [rmsm_pkg::APB_ADDR_W-1:0] paddr,
    input logic [rmsm_pkg::APB_DATA_W-1:0] pwdata,
    input logic [rmsm_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [rmsm_pkg::RMS_W-1:0]      rms_ct1,
    input logic [rmsm_pkg::RMS_W-1:0]      rms_ct2
);
    import rmsm_pkg::*;

    localparam logic [APB_ADDR_W-1:0] SCALE_ADDR = {REG_SCALE, 2'b00};

    // The port never inserts wait states
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // A result stays offered until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rms_ct1) && $stable(rms_ct2))
        else $error("result changed while stalled");

    // A scale write reads back on the following cycle
    a_scale_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == SCALE_ADDR)
        ##1 (paddr == SCALE_ADDR)
        |-> prdata == APB_DATA_W'($past(pwdata[SCALE_W-1:0])))
        else $error("scale readback mismatch");

endmodule

bind dual_channel_rms_meter rmsm_checker u_rmsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .rms_ct1   (results.rms_ct1),
    .rms_ct2   (results.rms_ct2)
);

// File: sim/tb_dual_channel_rms_meter.sv
`timescale 1ns / 1ps

// Testbench for the dual-channel RMS meter.
//
// Sample pairs go in through the samples interface; one pair of scaled RMS values comes
// out at the close of every window. A behavioural copy of the meter (offset filters,
// sums of squares, window counter, integer root and scaling) runs alongside and queues
// the result that each closing transfer should produce. Every result transfer is
// compared field by field against the oldest queued window.
//
// The run opens with a short table of hand-picked pairs, then walks a list of register
// settings. Each setting gets a burst of random pairs under its own idling pattern.
// Registers are only touched once the result queue has drained and the back end has had
// time to settle. Window counts do carry across settings, so a shrinking window gets
// exercised as well.
module tb_dual_channel_rms_meter;

    import rmsm_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 2;
    // a closing sample must pass the front stages, the queue and the back end before its result appears
    localparam int SETTLE_CYCLES   = 80;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    // limit on the whole run in ns, kept far above the slowest correct run
    localparam int RUN_LIMIT_NS    = 8_000_000;
    localparam int N_ROWS          = 24;
    localparam int N_PHASES        = 12;

    // index beyond the register map: a write here must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(3);

    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [RMS_W-1:0] rms_ct1;
        logic [RMS_W-1:0] rms_ct2;
    } rms_pair_t;

    // one hand-picked transfer; where typed is set the window result is given directly
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] s1;
        logic signed [SAMPLE_W-1:0] s2;
        logic                       typed;
        rms_pair_t                  want;
    } directed_row_t;

    // one register setting with its stimulus length and idling pattern
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [SHIFT_W-1:0] window_shift;
        logic [SHIFT_W-1:0] offset_shift;
        int                 items;
        int                 sender_pct;
        int                 receiver_pct;
        logic               hold;
    } phase_t;

    // Directed pairs, run with window shift 1 (a window every two transfers), offset
    // shift 4 and full scale. Two zero pairs straight after reset must give zero; the
    // long run at opposite rails drags the offsets hard over, so the rail swap that
    // follows pushes the root far enough to saturate the output.
    localparam directed_row_t DIRECTED [N_ROWS] = '{
        '{16'sd0,     16'sd0,     1'b0, '0},
        '{16'sd0,     16'sd0,     1'b1, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MAX,    SMP_MIN,    1'b0, '0},
        '{SMP_MAX,    SMP_MIN,    1'b0, '0},
        '{SMP_MIN,    SMP_MAX,    1'b0, '0},
        '{SMP_MAX,    SMP_MIN,    1'b0, '0},
        '{-16'sd1,    16'sd1,     1'b0, '0},
        '{16'sd1,     -16'sd1,    1'b0, '0},
        '{SMP_MAX,    SMP_MAX,    1'b0, '0},
        '{SMP_MIN,    SMP_MIN,    1'b0, '0},
        '{16'sh5555,  16'shAAAA,  1'b0, '0},
        '{16'shAAAA,  16'sh5555,  1'b0, '0}
    };

    // Register settings for the random part. Shift values outside the legal range (0, 3,
    // 17, 31) must act as the nearest limit. The phase at shift 31 leaves its window
    // open, so the small window straight after it closes on its first sample.
    localparam phase_t PHASES [N_PHASES] = '{
        '{16'd1234,  5'd2,  5'd5,  60,    0,  0,  1'b0},
        '{16'd0,     5'd0,  5'd0,  40,    56, 0,  1'b0},
        '{16'd65535, 5'd3,  5'd16, 60,    0,  56, 1'b0},
        '{16'd4000,  5'd1,  5'd3,  60,    0,  0,  1'b1},
        '{16'd777,   5'd31, 5'd31, 40,    0,  0,  1'b0},
        '{16'd100,   5'd2,  5'd7,  40,    9,  9,  1'b0},
        '{16'd250,   5'd11, 5'd10, 40,    9,  9,  1'b0},
        '{16'd40000, 5'd17, 5'd4,  30,    56, 0,  1'b0},
        '{16'd3,     5'd2,  5'd8,  60,    0,  56, 1'b0},
        '{16'd65535, 5'd4,  5'd12, 60,    0,  56, 1'b0},
        '{16'd9000,  5'd1,  5'd16, 40,    9,  9,  1'b0},
        '{16'd321,   5'd5,  5'd9,  60,    56, 0,  1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rmsm_in_if  samples_if ();
    rmsm_out_if results_if ();

    dual_channel_rms_meter dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_if.sink),
        .results (results_if.source)
    );

    // Behavioural copy of the meter: registers as written, then the datapath state
    logic [SCALE_W-1:0]        cfg_scale;
    logic [SHIFT_W-1:0]        cfg_window_shift;
    logic [SHIFT_W-1:0]        cfg_offset_shift;
    logic signed [OFF_W-1:0]   offset_ct1;
    logic signed [OFF_W-1:0]   offset_ct2;
    logic [SUM_W-1:0]          sq_sum_ct1;
    logic [SUM_W-1:0]          sq_sum_ct2;
    logic [COUNT_W-1:0]        window_count;

    rms_pair_t                 expected_rms [$];

    int                        mismatches = 0;
    int                        pairs_sent = 0;
    int                        windows_checked = 0;
    int                        sender_idle_pct = 0;
    int                        receiver_stall_pct = 0;
    int                        phase_amp = 0;
    logic signed [SAMPLE_W-1:0] phase_dc1;
    logic signed [SAMPLE_W-1:0] phase_dc2;
    bit                        hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d windows still expected", expected_rms.size());
        $display("** dual_channel_rms_meter: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int eff_window_shift();
        if (cfg_window_shift < WS_MIN)
            return int'(WS_MIN);
        if (cfg_window_shift > WS_MAX)
            return int'(WS_MAX);
        return int'(cfg_window_shift);
    endfunction

    function automatic int eff_offset_shift();
        if (cfg_offset_shift < OS_MIN)
            return int'(OS_MIN);
        if (cfg_offset_shift > OS_MAX)
            return int'(OS_MAX);
        return int'(cfg_offset_shift);
    endfunction

    // Floor of the square root, bit by bit from the top pair down
    function automatic logic [ROOT_W-1:0] root_floor(input logic [SUM_W-1:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[ROOT_W-1:0];
    endfunction

    // Mean square to output units: root in Q.8 counts, times scale, round half up
    function automatic logic [RMS_W-1:0] scaled_rms(input logic [SUM_W-1:0] sum, input int ws);
        logic [ROOT_W-1:0] root;
        logic [63:0]       v;
        root = root_floor(sum >> ws);
        v    = (64'(root) * 64'(cfg_scale) + 64'd128) >> ROUND_SHIFT;
        return (v > 64'(RMS_MAX)) ? RMS_MAX : v[RMS_W-1:0];
    endfunction

    // Offset filter step, offset removal and square accumulation for one channel
    task automatic accumulate_channel(input logic signed [SAMPLE_W-1:0] sample,
                                      input int shift,
                                      inout logic signed [OFF_W-1:0] offset,
                                      inout logic [SUM_W-1:0] sum);
        longint          scaled;
        longint          diff;
        longint          moved;
        longint          filt;
        longint unsigned mag;
        scaled = longint'(sample) * 65536;
        diff   = scaled - longint'(offset);
        moved  = longint'(offset) + (diff >>> shift);
        offset = moved[OFF_W-1:0];
        // the fresh offset applies to this same sample
        diff   = scaled - longint'(offset);
        filt   = diff >>> FILT_SHIFT;
        mag    = (filt < 0) ? -filt : filt;
        sum    = sum + mag * mag;
    endtask

    // Advance the meter copy by one pair; flag and return the result if a window closes
    task automatic advance_meter(input logic signed [SAMPLE_W-1:0] s1,
                                 input logic signed [SAMPLE_W-1:0] s2,
                                 output bit closed,
                                 output rms_pair_t rms);
        int os;
        int ws;
        int taken;
        os = eff_offset_shift();
        ws = eff_window_shift();
        accumulate_channel(s1, os, offset_ct1, sq_sum_ct1);
        accumulate_channel(s2, os, offset_ct2, sq_sum_ct2);
        closed = 1'b0;
        rms    = '0;
        taken  = int'(window_count) + 1;
        // reaching or passing the window length closes it, so a shrunk window closes at once
        if (taken >= (1 << ws))
        begin
            rms.rms_ct1  = scaled_rms(sq_sum_ct1, ws);
            rms.rms_ct2  = scaled_rms(sq_sum_ct2, ws);
            sq_sum_ct1   = '0;
            sq_sum_ct2   = '0;
            window_count = '0;
            closed       = 1'b1;
        end
        else
            window_count = COUNT_W'(taken);
    endtask

    // One APB write: setup cycle, then access cycle; mirror it into the meter copy
    task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                  input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (index)
            REG_SCALE:        cfg_scale        = data[SCALE_W-1:0];
            REG_WINDOW_SHIFT: cfg_window_shift = data[SHIFT_W-1:0];
            REG_OFFSET_SHIFT: cfg_offset_shift = data[SHIFT_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read every register back and compare with what was written
    task automatic check_registers();
        logic [APB_DATA_W-1:0] want;
        for (int i = REG_SCALE; i <= REG_OFFSET_SHIFT; i++)
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {REG_IDX_W'(i), 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (pready !== 1'b1);
            case (REG_IDX_W'(i))
                REG_SCALE:        want = APB_DATA_W'(cfg_scale);
                REG_WINDOW_SHIFT: want = APB_DATA_W'(cfg_window_shift);
                default:          want = APB_DATA_W'(cfg_offset_shift);
            endcase
            if (prdata !== want)
                report_mismatch($sformatf("register %0d reads %0h, want %0h", i, prdata, want));
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Write all three registers, with junk above each field to show it is masked off
    task automatic configure(input logic [SCALE_W-1:0] scale,
                             input logic [SHIFT_W-1:0] ws,
                             input logic [SHIFT_W-1:0] os);
        write_register(REG_SCALE,        {16'($urandom), scale});
        write_register(REG_WINDOW_SHIFT, {27'($urandom), ws});
        write_register(REG_OFFSET_SHIFT, {27'($urandom), os});
        check_registers();
    endtask

    // Mostly a DC level with noise on top, plus fully random words and the rails
    function automatic logic signed [SAMPLE_W-1:0] make_sample(
        input logic signed [SAMPLE_W-1:0] dc);
        int                         pick;
        logic signed [SAMPLE_W-1:0] noise;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            noise = SAMPLE_W'($urandom_range(0, 2 * phase_amp)) - SAMPLE_W'(phase_amp);
            return dc + noise;
        end
        if (pick < 80)
            return SAMPLE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Offer one pair, idling first at the current rate; entered and left at a falling edge
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] s1,
                             input logic signed [SAMPLE_W-1:0] s2,
                             input logic typed,
                             input rms_pair_t typed_rms);
        bit        closed;
        rms_pair_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(negedge clk);
        end
        samples_if.valid      <= 1'b1;
        samples_if.sample_ct1 <= s1;
        samples_if.sample_ct2 <= s2;
        do @(posedge clk); while (samples_if.ready !== 1'b1);
        // the transfer happened at this edge
        advance_meter(s1, s2, closed, predicted);
        if (closed)
            expected_rms.push_back(typed ? typed_rms : predicted);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Wait for every queued window, then let the back end go quiet before any write
    task automatic drain_results();
        int waited;
        waited = 0;
        while (expected_rms.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_rms.size() != 0)
        begin
            report_mismatch($sformatf("%0d window results never arrived", expected_rms.size()));
            expected_rms.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls at the current rate, and on request one long hold-off
    // so the window queue fills and the input has to stall
    initial
    begin
        int held;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                begin
                    results_if.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            results_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Compare every result transfer against the oldest queued window
    always @(posedge clk)
    begin : check_results
        rms_pair_t want;
        if (rst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1)
        begin
            if (expected_rms.size() == 0)
                report_mismatch($sformatf("result %0d/%0d with no window closed",
                                          results_if.rms_ct1, results_if.rms_ct2));
            else
            begin
                want = expected_rms.pop_front();
                if (results_if.rms_ct1 !== want.rms_ct1)
                    report_mismatch($sformatf("rms_ct1 got %0d, want %0d",
                                              results_if.rms_ct1, want.rms_ct1));
                if (results_if.rms_ct2 !== want.rms_ct2)
                    report_mismatch($sformatf("rms_ct2 got %0d, want %0d",
                                              results_if.rms_ct2, want.rms_ct2));
                windows_checked++;
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t row;
        phase_t        ph;

        // Drive every input to a known level and hold reset
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        samples_if.valid      = 1'b0;
        samples_if.sample_ct1 = '0;
        samples_if.sample_ct2 = '0;
        cfg_scale             = SCALE_RST;
        cfg_window_shift      = WS_RST;
        cfg_offset_shift      = OS_RST;
        offset_ct1            = '0;
        offset_ct2            = '0;
        sq_sum_ct1            = '0;
        sq_sum_ct2            = '0;
        window_count          = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset values first, then a write past the map that must change nothing
        check_registers();
        write_register(REG_SPARE, $urandom);
        configure(16'hFFFF, WS_MIN, OS_MIN);

        // Directed table
        sender_idle_pct    = 9;
        receiver_stall_pct = 9;
        for (int r = 0; r < N_ROWS; r++)
        begin
            row = DIRECTED[r];
            send_pair(row.s1, row.s2, row.typed, row.want);
        end
        samples_if.valid <= 1'b0;
        drain_results();

        // Random part, one register setting at a time
        for (int p = 0; p < N_PHASES; p++)
        begin
            ph = PHASES[p];
            configure(ph.scale, ph.window_shift, ph.offset_shift);
            sender_idle_pct    = ph.sender_pct;
            receiver_stall_pct = ph.receiver_pct;
            phase_dc1          = SAMPLE_W'($urandom);
            phase_dc2          = SAMPLE_W'($urandom);
            phase_amp          = $urandom_range(0, 8191);
            if (ph.hold)
                hold_request = 1'b1;
            for (int k = 0; k < ph.items; k++)
                send_pair(make_sample(phase_dc1), make_sample(phase_dc2), 1'b0, '0);
            samples_if.valid <= 1'b0;
            drain_results();
        end

        $display("Covered %0d sample pairs over %0d register settings, %0d windows compared",
                 pairs_sent, N_PHASES + 1, windows_checked);
        $display("Included shift limits and out-of-range shifts, zero and full scale, a %0d-cycle",
                 HOLD_OFF_CYCLES);
        $display("output hold-off and windows shrunk part way");
        if (mismatches == 0)
            $display("** dual_channel_rms_meter: PASSED **");
        else
            $display("** dual_channel_rms_meter: FAILED **");
        $finish;
    end

endmodule
